[rtl/ccc_pkg.sv]
// ---------------------------------------------------------------------------
// ccc_pkg
// shared widths, defaults and command codes for the circle collision checker
// ---------------------------------------------------------------------------
package ccc_pkg;

    localparam int COORD_W = 24;
    localparam int RAD_W   = 16;

    localparam int MAX_ROBOTS_DEF    = 8;
    localparam int MAX_OBSTACLES_DEF = 64;

    localparam logic [RAD_W-1:0] RADIUS_RESET = 16'd717;

    typedef enum logic [1:0] {
        CMD_UPDATE = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_CHECK  = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

endpackage

[rtl/circle_collision_checker.sv]
// ---------------------------------------------------------------------------
// circle_collision_checker
// robot position table and obstacle list with a pairwise overlap check
// ---------------------------------------------------------------------------
// usage:
//   input beats (in_valid/in_ready) carry a command: robot position update,
//   obstacle append, collision check or obstacle clear. only a check makes
//   an output beat (out_valid/out_ready) holding the collision flag.
//   cfg_wr_en/cfg_wr_data: robot radius, user writes while idle, unchecked.
// timing:
//   update, append and clear are taken while idle. a check walks the robot
//   ram and the obstacle ram, at most one distance test issued per cycle
//   through a four stage read/subtract/square/compare pipeline. for each
//   valid robot slot i it loads that robot, tests it against every valid
//   slot above i and then every obstacle; empty slots are skipped. the
//   pipeline then drains and the flag is handed to the output register.
// reset:
//   all robot slots invalid, obstacle list empty, radius 717 (about 2.8 m).
// stalls:
//   a finished flag waits in the output register; updates, appends and
//   clears are still taken meanwhile, a further check holds in its last
//   cycle until the waiting flag has been taken.
// ---------------------------------------------------------------------------
module circle_collision_checker #(
    parameter int MAX_ROBOTS    = ccc_pkg::MAX_ROBOTS_DEF,
    parameter int MAX_OBSTACLES = ccc_pkg::MAX_OBSTACLES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [1:0]                        cmd,
    input  logic [2:0]                        robot_index,
    input  logic signed [ccc_pkg::COORD_W-1:0] pos_x,
    input  logic signed [ccc_pkg::COORD_W-1:0] pos_y,
    input  logic [ccc_pkg::RAD_W-1:0]         obstacle_radius,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              collision,
    input  logic                              cfg_wr_en,
    input  logic [ccc_pkg::RAD_W-1:0]         cfg_wr_data
);

    localparam int CW     = ccc_pkg::COORD_W;
    localparam int RW     = ccc_pkg::RAD_W;
    localparam int SQ_W   = 2 * CW;
    localparam int THR_W  = RW + 1;
    localparam int ROB_AW = (MAX_ROBOTS > 1) ? $clog2(MAX_ROBOTS) : 1;
    localparam int ROB_CW = $clog2(MAX_ROBOTS + 1);
    localparam int OBS_AW = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
    localparam int OBS_CW = $clog2(MAX_OBSTACLES + 1);
    localparam int ROB_DW = 2 * CW;
    localparam int OBS_DW = 2 * CW + RW;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_LOAD   = 6'b000010,
        S_ROBOTS = 6'b000100,
        S_OBST   = 6'b001000,
        S_DRAIN  = 6'b010000,
        S_DONE   = 6'b100000
    } state_t;

    state_t              state_reg, state_next;
    logic [RW-1:0]       radius_reg;
    logic [MAX_ROBOTS-1:0] seen_reg, seen_next;
    logic [OBS_CW-1:0]   obs_count_reg, obs_count_next;
    logic [ROB_AW-1:0]   i_reg, i_next;
    logic [ROB_CW-1:0]   j_reg, j_next;
    logic [OBS_CW-1:0]   o_reg, o_next;
    logic                hit_reg, hit_next;
    logic                load_pend_reg;
    logic                p1_valid_reg, p1_obst_reg;
    logic                p2_valid_reg, p3_valid_reg;
    logic                out_valid_reg, collision_reg;

    logic [CW-1:0]       a_x_reg, a_y_reg;
    logic [CW-1:0]       p2_dx_reg, p2_dy_reg;
    logic [THR_W-1:0]    p2_thr_reg;
    logic [SQ_W-1:0]     p3_dx2_reg, p3_dy2_reg;
    logic [2*THR_W-1:0]  p3_thr2_reg;

    logic                accept;
    logic                rob_we, obs_we;
    logic [ROB_AW-1:0]   rob_waddr, rob_raddr;
    logic [ROB_DW-1:0]   rob_rdata;
    logic [OBS_DW-1:0]   obs_rdata;
    logic                load_issue, issue_rob, issue_obs, out_set;
    logic                i_last;

    logic [CW-1:0]       b_x, b_y;
    logic signed [CW:0]  dx, dy;
    logic [CW:0]         dx_abs, dy_abs;
    logic [THR_W-1:0]    thr;
    logic [SQ_W:0]       dist2;

    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign collision = collision_reg;
    assign i_last    = (i_reg == ROB_AW'(MAX_ROBOTS - 1));

    // table writes
    assign rob_we    = accept && (cmd == ccc_pkg::CMD_UPDATE) &&
                       (32'(robot_index) < MAX_ROBOTS);
    assign rob_waddr = ROB_AW'(robot_index);
    assign obs_we    = accept && (cmd == ccc_pkg::CMD_APPEND) &&
                       (obs_count_reg != OBS_CW'(MAX_OBSTACLES));

    ccc_ram #(
        .WIDTH (ROB_DW),
        .DEPTH (MAX_ROBOTS)
    ) u_robot_ram (
        .clk   (clk),
        .we    (rob_we),
        .waddr (rob_waddr),
        .wdata ({pos_x, pos_y}),
        .raddr (rob_raddr),
        .rdata (rob_rdata)
    );

    ccc_ram #(
        .WIDTH (OBS_DW),
        .DEPTH (MAX_OBSTACLES)
    ) u_obstacle_ram (
        .clk   (clk),
        .we    (obs_we),
        .waddr (obs_count_reg[OBS_AW-1:0]),
        .wdata ({pos_x, pos_y, obstacle_radius}),
        .raddr (o_reg[OBS_AW-1:0]),
        .rdata (obs_rdata)
    );

    always_comb
    begin
        seen_next      = seen_reg;
        obs_count_next = obs_count_reg;
        if (rob_we)
        begin
            seen_next[rob_waddr] = 1'b1;
        end
        if (obs_we)
        begin
            obs_count_next = obs_count_reg + OBS_CW'(1);
        end
        if (accept && (cmd == ccc_pkg::CMD_CLEAR))
        begin
            obs_count_next = '0;
        end
    end

    // check sequencer
    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        o_next     = o_reg;
        hit_next   = hit_reg;
        rob_raddr  = j_reg[ROB_AW-1:0];
        load_issue = 1'b0;
        issue_rob  = 1'b0;
        issue_obs  = 1'b0;
        out_set    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (cmd == ccc_pkg::CMD_CHECK))
                begin
                    i_next     = '0;
                    hit_next   = 1'b0;
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                if (seen_reg[i_reg])
                begin
                    rob_raddr  = i_reg;
                    load_issue = 1'b1;
                    j_next     = ROB_CW'(i_reg) + ROB_CW'(1);
                    o_next     = '0;
                    state_next = S_ROBOTS;
                end
                else if (i_last)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    i_next = i_reg + ROB_AW'(1);
                end
            end
            S_ROBOTS:
            begin
                if (j_reg == ROB_CW'(MAX_ROBOTS))
                begin
                    state_next = S_OBST;
                end
                else
                begin
                    issue_rob = seen_reg[j_reg[ROB_AW-1:0]];
                    j_next    = j_reg + ROB_CW'(1);
                end
            end
            S_OBST:
            begin
                if (o_reg == obs_count_reg)
                begin
                    if (i_last)
                    begin
                        state_next = S_DRAIN;
                    end
                    else
                    begin
                        i_next     = i_reg + ROB_AW'(1);
                        state_next = S_LOAD;
                    end
                end
                else
                begin
                    issue_obs = 1'b1;
                    o_next    = o_reg + OBS_CW'(1);
                end
            end
            S_DRAIN:
            begin
                if (!p1_valid_reg && !p2_valid_reg && !p3_valid_reg)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_set    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (p3_valid_reg && (dist2 < (SQ_W + 1)'(p3_thr2_reg)))
        begin
            hit_next = 1'b1;
        end
    end

    // distance datapath
    always_comb
    begin
        b_x = p1_obst_reg ? obs_rdata[OBS_DW-1 -: CW] : rob_rdata[ROB_DW-1 -: CW];
        b_y = p1_obst_reg ? obs_rdata[RW +: CW]       : rob_rdata[CW-1:0];
        dx  = $signed({a_x_reg[CW-1], a_x_reg}) - $signed({b_x[CW-1], b_x});
        dy  = $signed({a_y_reg[CW-1], a_y_reg}) - $signed({b_y[CW-1], b_y});
        dx_abs = dx[CW] ? (~dx + 1'b1) : dx;
        dy_abs = dy[CW] ? (~dy + 1'b1) : dy;
        if (p1_obst_reg)
        begin
            thr = {1'b0, radius_reg} + {1'b0, obs_rdata[RW-1:0]};
        end
        else
        begin
            thr = {radius_reg, 1'b0};
        end
        dist2 = {1'b0, p3_dx2_reg} + {1'b0, p3_dy2_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            radius_reg    <= ccc_pkg::RADIUS_RESET;
            seen_reg      <= '0;
            obs_count_reg <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            o_reg         <= '0;
            hit_reg       <= 1'b0;
            load_pend_reg <= 1'b0;
            p1_valid_reg  <= 1'b0;
            p1_obst_reg   <= 1'b0;
            p2_valid_reg  <= 1'b0;
            p3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            collision_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            seen_reg      <= seen_next;
            obs_count_reg <= obs_count_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            o_reg         <= o_next;
            hit_reg       <= hit_next;
            load_pend_reg <= load_issue;
            p1_valid_reg  <= issue_rob || issue_obs;
            p1_obst_reg   <= issue_obs;
            p2_valid_reg  <= p1_valid_reg;
            p3_valid_reg  <= p2_valid_reg;
            if (cfg_wr_en)
            begin
                radius_reg <= cfg_wr_data;
            end
            if (out_set)
            begin
                out_valid_reg <= 1'b1;
                collision_reg <= hit_reg;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_pend_reg)
        begin
            a_x_reg <= rob_rdata[ROB_DW-1 -: CW];
            a_y_reg <= rob_rdata[CW-1:0];
        end
        p2_dx_reg   <= dx_abs[CW-1:0];
        p2_dy_reg   <= dy_abs[CW-1:0];
        p2_thr_reg  <= thr;
        p3_dx2_reg  <= p2_dx_reg * p2_dx_reg;
        p3_dy2_reg  <= p2_dy_reg * p2_dy_reg;
        p3_thr2_reg <= p2_thr_reg * p2_thr_reg;
    end

endmodule

[rtl/ccc_ram.sv]
// ---------------------------------------------------------------------------
// ccc_ram
// generic single write port, single read port ram with registered read
// ---------------------------------------------------------------------------
module ccc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                         clk,
    input  logic                                         we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                             wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/ccc_checker.sv]
// ---------------------------------------------------------------------------
// ccc_checker
// port level checks on the circle collision checker, bound to the top level
// ---------------------------------------------------------------------------
module ccc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [1:0] cmd,
    input logic       out_valid,
    input logic       out_ready,
    input logic       collision
);

    // a waiting flag beat is not dropped
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("flag beat dropped while stalled");

    // a waiting flag beat keeps its value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(collision))
        else $error("flag changed while stalled");

    // only a check beat yields a flag
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (cmd != ccc_pkg::CMD_CHECK) |=> !$rose(out_valid))
        else $error("flag without a check");

    // a check occupies the block
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (cmd == ccc_pkg::CMD_CHECK) |=> !in_ready)
        else $error("input taken during a check");

    // a new flag appears only at the end of a check
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("flag raised while idle");

endmodule

bind circle_collision_checker ccc_checker u_ccc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .collision (collision)
);

[dv/testbench.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// drives robot updates, obstacle appends, clears and collision checks into
// the circle collision checker at several robot radius settings, predicts
// each collision flag from a private copy of the robot table and obstacle
// list, and compares every output beat against the oldest prediction
// ---------------------------------------------------------------------------
module testbench;

    localparam int COORD_W         = ccc_pkg::COORD_W;
    localparam int RAD_W           = ccc_pkg::RAD_W;
    localparam int N_ROBOTS        = ccc_pkg::MAX_ROBOTS_DEF;
    localparam int N_OBSTACLES     = ccc_pkg::MAX_OBSTACLES_DEF;
    localparam int N_PHASES        = 6;
    localparam int DIRECTED_BEATS  = 18;
    localparam int BEATS_PER_PHASE = 165;
    localparam int SETTLE_CYCLES   = 8;
    localparam int DRAIN_CYCLES    = 20;
    localparam int STALL_LIMIT     = 5000;

    localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
    localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic [RAD_W-1:0]          RAD_MAX   = '1;

    class collision_scoreboard;
        logic [RAD_W-1:0]          radius;
        logic signed [COORD_W-1:0] robot_x [N_ROBOTS];
        logic signed [COORD_W-1:0] robot_y [N_ROBOTS];
        bit                        robot_live [N_ROBOTS];
        logic signed [COORD_W-1:0] obst_x [N_OBSTACLES];
        logic signed [COORD_W-1:0] obst_y [N_OBSTACLES];
        logic [RAD_W-1:0]          obst_r [N_OBSTACLES];
        int                        obst_count;
        bit                        expected_flags [$];
        int                        errors;
        int                        checks;
        int                        hits;
        int                        refused;

        function new();
            radius     = ccc_pkg::RADIUS_RESET;
            obst_count = 0;
            errors     = 0;
            checks     = 0;
            hits       = 0;
            refused    = 0;
            foreach (robot_live[i])
                robot_live[i] = 1'b0;
        endfunction

        function void set_radius(input logic [RAD_W-1:0] r);
            radius = r;
        endfunction

        function int pending();
            return expected_flags.size();
        endfunction

        // squared distance strictly below squared threshold
        function bit closer_than(input logic signed [COORD_W-1:0] ax, ay, bx, by,
                                 input longint thr);
            longint dx;
            longint dy;
            dx = ax;
            dx = dx - bx;
            dy = ay;
            dy = dy - by;
            return (dx * dx + dy * dy) < (thr * thr);
        endfunction

        function bit collision_flag();
            bit     hit;
            longint pair_thr;
            longint thr;
            hit      = 1'b0;
            pair_thr = radius;
            pair_thr = pair_thr * 2;
            for (int i = 0; i < N_ROBOTS; i++)
            begin
                if (robot_live[i])
                begin
                    for (int j = i + 1; j < N_ROBOTS; j++)
                        if (robot_live[j] && closer_than(robot_x[i], robot_y[i],
                                                         robot_x[j], robot_y[j], pair_thr))
                            hit = 1'b1;
                    for (int j = 0; j < obst_count; j++)
                    begin
                        thr = radius;
                        thr = thr + obst_r[j];
                        if (closer_than(robot_x[i], robot_y[i], obst_x[j], obst_y[j], thr))
                            hit = 1'b1;
                    end
                end
            end
            return hit;
        endfunction

        function void note_beat(input ccc_pkg::cmd_t op, input logic [2:0] slot,
                                input logic signed [COORD_W-1:0] x, y,
                                input logic [RAD_W-1:0] rad);
            bit flag;
            case (op)
                ccc_pkg::CMD_UPDATE:
                begin
                    if (slot < N_ROBOTS)
                    begin
                        robot_x[slot]    = x;
                        robot_y[slot]    = y;
                        robot_live[slot] = 1'b1;
                    end
                end
                ccc_pkg::CMD_APPEND:
                begin
                    if (obst_count < N_OBSTACLES)
                    begin
                        obst_x[obst_count] = x;
                        obst_y[obst_count] = y;
                        obst_r[obst_count] = rad;
                        obst_count++;
                    end
                    else
                        refused++;
                end
                ccc_pkg::CMD_CHECK:
                begin
                    flag = collision_flag();
                    expected_flags = {expected_flags, flag};
                    checks++;
                    if (flag)
                        hits++;
                end
                ccc_pkg::CMD_CLEAR:
                    obst_count = 0;
            endcase
        endfunction

        function void check_flag(input logic got);
            bit want;
            if (expected_flags.size() == 0)
            begin
                $display("%0t: collision beat with no check outstanding, expected none, got %0b",
                         $time, got);
                errors++;
            end
            else
            begin
                want = expected_flags.pop_front();
                if (got !== want)
                begin
                    $display("%0t: collision flag mismatch, expected %0b, got %0b",
                             $time, want, got);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    logic [1:0]                cmd;
    logic [2:0]                robot_index;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic [RAD_W-1:0]          obstacle_radius;
    logic                      out_valid;
    logic                      out_ready;
    logic                      collision;
    logic                      cfg_wr_en;
    logic [RAD_W-1:0]          cfg_wr_data;

    collision_scoreboard flags;
    int                  idle_pct;
    int                  beats_sent;
    logic [RAD_W-1:0]    radius_plan [N_PHASES];

    circle_collision_checker u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .cmd             (cmd),
        .robot_index     (robot_index),
        .pos_x           (pos_x),
        .pos_y           (pos_y),
        .obstacle_radius (obstacle_radius),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .collision       (collision),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic signed [COORD_W-1:0] rand_coord();
        case ($urandom_range(7))
            0:       return COORD_MIN;
            1:       return COORD_MAX;
            2:       return '0;
            default: return COORD_W'($urandom);
        endcase
    endfunction

    function automatic logic signed [COORD_W-1:0] jitter(input logic signed [COORD_W-1:0] centre,
                                                         input int spread);
        int offs;
        offs = int'($urandom_range(2 * spread)) - spread;
        return COORD_W'(centre + offs);
    endfunction

    function automatic logic [RAD_W-1:0] rand_radius();
        if ($urandom_range(1) == 0)
            return RAD_W'($urandom_range(3000));
        else
            return RAD_W'($urandom);
    endfunction

    task automatic put_beat(input ccc_pkg::cmd_t op, input logic [2:0] slot,
                            input logic signed [COORD_W-1:0] x, y,
                            input logic [RAD_W-1:0] rad);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid        <= 1'b1;
        cmd             <= op;
        robot_index     <= slot;
        pos_x           <= x;
        pos_y           <= y;
        obstacle_radius <= rad;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        flags.note_beat(op, slot, x, y, rad);
        beats_sent++;
    endtask

    // command with random filler in the fields it ignores
    task automatic put_bare(input ccc_pkg::cmd_t op);
        put_beat(op, 3'($urandom), COORD_W'($urandom), COORD_W'($urandom), RAD_W'($urandom));
    endtask

    task automatic write_radius(input logic [RAD_W-1:0] r);
        in_valid <= 1'b0;
        while (flags.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= r;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        flags.set_radius(r);
    endtask

    // one scene: robots and obstacles grouped round a centre, then a check
    task automatic run_scene();
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        int                        spread;
        int                        n_upd;
        int                        n_app;
        cx = rand_coord();
        cy = rand_coord();
        case ($urandom_range(3))
            0:       spread = 400;
            1:       spread = 2500;
            2:       spread = 30000;
            default: spread = 1 << 22;
        endcase
        if ($urandom_range(2) == 0)
            put_bare(ccc_pkg::CMD_CLEAR);
        n_upd = $urandom_range(N_ROBOTS);
        for (int k = 0; k < n_upd; k++)
            put_beat(ccc_pkg::CMD_UPDATE, 3'($urandom_range(N_ROBOTS - 1)),
                     jitter(cx, spread), jitter(cy, spread), RAD_W'($urandom));
        if ($urandom_range(2) == 0)
            put_bare(ccc_pkg::CMD_CHECK);
        // now and then overfill the obstacle list
        if ($urandom_range(9) == 0)
            n_app = $urandom_range(72, 56);
        else
            n_app = $urandom_range(6);
        for (int k = 0; k < n_app; k++)
            put_beat(ccc_pkg::CMD_APPEND, 3'($urandom), jitter(cx, spread),
                     jitter(cy, spread), rand_radius());
        put_bare(ccc_pkg::CMD_CHECK);
        if ($urandom_range(9) == 0)
            put_bare(ccc_pkg::cmd_t'($urandom_range(3)));
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            flags.check_flag(collision);
        out_ready <= ($urandom_range(99) >= idle_pct);
    end

    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        rst_n           <= 1'b0;
        in_valid        <= 1'b0;
        cmd             <= ccc_pkg::CMD_UPDATE;
        robot_index     <= '0;
        pos_x           <= '0;
        pos_y           <= '0;
        obstacle_radius <= '0;
        out_ready       <= 1'b0;
        cfg_wr_en       <= 1'b0;
        cfg_wr_data     <= '0;
        idle_pct        = 12;
        beats_sent      = 0;
        flags           = new();
        radius_plan[0]  = ccc_pkg::RADIUS_RESET;
        radius_plan[1]  = '0;
        radius_plan[2]  = RAD_MAX;
        radius_plan[3]  = RAD_W'(1);
        radius_plan[4]  = RAD_W'($urandom_range(4096, 256));
        radius_plan[5]  = ccc_pkg::RADIUS_RESET;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty tables, touching and overlapping pairs, extreme coordinates
        put_bare(ccc_pkg::CMD_CHECK);
        put_beat(ccc_pkg::CMD_UPDATE, 3'd0, '0, '0, RAD_W'($urandom));
        put_bare(ccc_pkg::CMD_CHECK);
        put_beat(ccc_pkg::CMD_UPDATE, 3'd1, COORD_W'(2 * ccc_pkg::RADIUS_RESET), '0,
                 RAD_W'($urandom));
        put_bare(ccc_pkg::CMD_CHECK);
        put_beat(ccc_pkg::CMD_UPDATE, 3'd1, COORD_W'(2 * ccc_pkg::RADIUS_RESET - 1), '0,
                 RAD_W'($urandom));
        put_bare(ccc_pkg::CMD_CHECK);
        put_beat(ccc_pkg::CMD_UPDATE, 3'd0, COORD_MIN, COORD_MIN, RAD_W'($urandom));
        put_beat(ccc_pkg::CMD_UPDATE, 3'd7, COORD_MAX, COORD_MAX, RAD_W'($urandom));
        put_beat(ccc_pkg::CMD_UPDATE, 3'd1, COORD_MAX, COORD_MIN, RAD_W'($urandom));
        put_bare(ccc_pkg::CMD_CHECK);
        put_beat(ccc_pkg::CMD_APPEND, 3'($urandom), COORD_MIN,
                 COORD_W'(COORD_MIN + ccc_pkg::RADIUS_RESET + RAD_MAX), RAD_MAX);
        put_bare(ccc_pkg::CMD_CHECK);
        put_beat(ccc_pkg::CMD_APPEND, 3'($urandom),
                 COORD_W'(COORD_MIN + ccc_pkg::RADIUS_RESET + RAD_MAX - 1), COORD_MIN,
                 RAD_MAX);
        put_bare(ccc_pkg::CMD_CHECK);
        put_bare(ccc_pkg::CMD_CLEAR);
        put_bare(ccc_pkg::CMD_CHECK);
        put_beat(ccc_pkg::CMD_APPEND, 3'($urandom), '0, '0, '0);

        for (int phase = 0; phase < N_PHASES; phase++)
        begin
            if (phase != 0)
                write_radius(radius_plan[phase]);
            // one whole phase runs with both sides flat out
            idle_pct = (phase == 2) ? 0 : 12;
            while (beats_sent < DIRECTED_BEATS + BEATS_PER_PHASE * (phase + 1))
                run_scene();
        end
        in_valid <= 1'b0;
        while (flags.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d command beats over %0d robot radius settings from 0 to full scale",
                 beats_sent, N_PHASES);
        $display("%0d checks, %0d with a collision, %0d appends refused on a full list",
                 flags.checks, flags.hits, flags.refused);
        if (flags.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
